/* hw/rtl/batb_pkg.sv */
package batb_pkg;

  localparam int unsigned LOG_DEPTH = 1024;
  localparam int unsigned ADDR_W    = $clog2(LOG_DEPTH);
  localparam int unsigned COUNT_W   = $clog2(LOG_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_NEW        = 3'd0,
    ST_GROUPED    = 3'd1,
    ST_DROPPED    = 3'd2,
    ST_OUTSIDE    = 3'd3,
    ST_READ_OK    = 3'd4,
    ST_READ_RANGE = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    CFG_ENTRIES_IN_USE   = 3'd0,
    CFG_OVERWRITE_ENABLE = 3'd1,
    CFG_WINDOW_COUNT     = 3'd2,
    CFG_LAST_WINDOW_OPEN = 3'd3,
    CFG_WINDOW0_START    = 3'd4,
    CFG_WINDOW0_END      = 3'd5,
    CFG_WINDOW1_START    = 3'd6,
    CFG_WINDOW1_END      = 3'd7
  } cfg_idx_t;

  // Bit order matches bar | write << 3 | space << 4 | len << 6.
  typedef struct packed {
    logic [7:0] len;
    logic [1:0] space;
    logic       write;
    logic [2:0] bar;
  } key_t;

  typedef struct packed {
    logic [63:0] time_stamp;
    logic [63:0] data;
    logic [63:0] base;
    logic [31:0] offset;
    logic [31:0] repeats;
    key_t        key;
  } entry_t;

endpackage

/* hw/rtl/bus_access_trace_buffer_unit.sv */
// Bus access trace buffer. Each command (start high while busy is low) is
// either a logged access event or a read-out request, and it always yields
// exactly one result, shown on the out_ ports for one cycle with out_valid
// high in the cycle after the command transfer. busy never rises, so a command
// may be issued in every cycle and the block takes one item per clock; the
// figure is set by the single write port and the single registered read port
// of the trace memory, each used at most once per item. The receiver cannot
// stall: a result that is not taken in its cycle is lost. Stored entries are
// not cleared at reset; only entries written since the last reset or ring
// resize are ever returned. Writing entries_in_use empties the store.
module bus_access_trace_buffer_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration write port.
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [63:0]                   cfg_wdata,
  // Command channel.
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_action,
  input  logic                          in_group_mode,
  input  logic [63:0]                   in_now_time,
  input  logic [2:0]                    in_bar_number,
  input  logic                          in_is_write,
  input  logic [1:0]                    in_space_type,
  input  logic [63:0]                   in_window_base,
  input  logic [31:0]                   in_access_offset,
  input  logic [7:0]                    in_access_len,
  input  logic [63:0]                   in_access_data,
  input  logic [9:0]                    in_read_index,
  // Result channel.
  output logic                          out_valid,
  output logic [2:0]                    out_status,
  output logic [10:0]                   out_stored_count,
  output logic [63:0]                   out_entry_time,
  output logic [63:0]                   out_entry_data,
  output logic [63:0]                   out_entry_base,
  output logic [31:0]                   out_entry_offset,
  output logic [31:0]                   out_entry_repeats,
  output logic [2:0]                    out_entry_bar,
  output logic                          out_entry_write,
  output logic [1:0]                    out_entry_space,
  output logic [7:0]                    out_entry_len
);

  localparam int unsigned AW = batb_pkg::ADDR_W;
  localparam int unsigned CW = batb_pkg::COUNT_W;

  // Configuration registers.
  logic [10:0] entries_in_use_r;
  logic        overwrite_enable_r;
  logic [1:0]  window_count_r;
  logic        last_window_open_r;
  logic [63:0] window0_start_r, window0_end_r, window1_start_r, window1_end_r;

  // Ring state.
  logic [AW-1:0] write_pointer_r, write_pointer_nxt;
  logic [CW-1:0] held_count_r, held_count_nxt;

  // Copy of the newest entry's match fields and repeat count, so that a
  // grouped access can be compared without a memory read.
  batb_pkg::key_t newest_key_r, newest_key_nxt;
  logic [63:0]    newest_base_r, newest_base_nxt;
  logic [31:0]    newest_offset_r, newest_offset_nxt;
  logic [31:0]    newest_repeats_r, newest_repeats_nxt;
  logic [AW-1:0]  newest_addr_r, newest_addr_nxt;

  // Trace memory.
  batb_pkg::entry_t mem [batb_pkg::LOG_DEPTH];
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  batb_pkg::entry_t mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  batb_pkg::entry_t rdata_r;

  // Result registers.
  logic              out_valid_r;
  batb_pkg::status_t status_r, status_nxt;
  logic [CW-1:0]     stored_count_r;
  logic              read_ok_r;

  logic              accept;
  logic [CW-1:0]     ring_n;
  logic              in_win0, in_win1, time_ok;
  batb_pkg::key_t    in_key;
  logic [63:0]       data_mask;
  logic [CW:0]       rd_sum;
  logic              read_hit;
  logic [CW-1:0]     wp_inc;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Ring size: zero behaves as one, anything past the depth as the depth.
  always_comb begin
    if (entries_in_use_r == '0) begin
      ring_n = CW'(1);
    end else if (entries_in_use_r > 11'(batb_pkg::LOG_DEPTH)) begin
      ring_n = CW'(batb_pkg::LOG_DEPTH);
    end else begin
      ring_n = CW'(entries_in_use_r);
    end
  end

  // Time filter. With one window the open-end flag applies to window 0,
  // with two (window_count 3 behaves as 2) it applies to window 1.
  always_comb begin
    in_win0 = (in_now_time >= window0_start_r) &&
              ((last_window_open_r && window_count_r == 2'd1) ||
               (in_now_time < window0_end_r));
    in_win1 = (in_now_time >= window1_start_r) &&
              (last_window_open_r || (in_now_time < window1_end_r));
    if (window_count_r == 2'd0) begin
      time_ok = 1'b1;
    end else if (window_count_r == 2'd1) begin
      time_ok = in_win0;
    end else begin
      time_ok = in_win0 || in_win1;
    end
  end

  assign in_key = '{len: in_access_len, space: in_space_type,
                    write: in_is_write, bar: in_bar_number};

  // Keep only the first access_len bytes of the data.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      data_mask[8*i +: 8] = {8{in_access_len > 8'(i)}};
    end
  end

  // Entry k counted from the oldest: (wp + n - held + k) mod n. The sum
  // stays below 2n because k < held, so one conditional subtract suffices.
  always_comb begin
    rd_sum = (CW+1)'(write_pointer_r) + (CW+1)'(ring_n) - (CW+1)'(held_count_r)
             + (CW+1)'(in_read_index);
    if (rd_sum >= (CW+1)'(ring_n)) begin
      rd_sum = rd_sum - (CW+1)'(ring_n);
    end
    mem_raddr = rd_sum[AW-1:0];
  end

  assign read_hit = CW'(in_read_index) < held_count_r;
  assign wp_inc   = CW'(write_pointer_r) + CW'(1);

  // Command decode and ring update.
  always_comb begin
    write_pointer_nxt  = write_pointer_r;
    held_count_nxt     = held_count_r;
    newest_key_nxt     = newest_key_r;
    newest_base_nxt    = newest_base_r;
    newest_offset_nxt  = newest_offset_r;
    newest_repeats_nxt = newest_repeats_r;
    newest_addr_nxt    = newest_addr_r;
    status_nxt         = status_r;
    mem_we             = 1'b0;
    mem_waddr          = write_pointer_r;
    mem_wdata          = '{time_stamp: in_now_time,
                           data:       in_access_data & data_mask,
                           base:       in_window_base,
                           offset:     in_access_offset,
                           repeats:    {31'd0, in_group_mode},
                           key:        in_key};
    mem_re             = 1'b0;

    if (accept) begin
      if (in_action) begin
        mem_re     = read_hit;
        status_nxt = read_hit ? batb_pkg::ST_READ_OK : batb_pkg::ST_READ_RANGE;
      end else if (!time_ok) begin
        status_nxt = batb_pkg::ST_OUTSIDE;
      end else if (in_group_mode && held_count_r != '0 &&
                   newest_key_r == in_key && newest_base_r == in_window_base &&
                   newest_offset_r == in_access_offset) begin
        // Repeat of the newest entry: bump its count in place, even when full.
        newest_repeats_nxt = newest_repeats_r + 32'd1;
        mem_we             = 1'b1;
        mem_waddr          = newest_addr_r;
        mem_wdata.time_stamp = rdata_r.time_stamp;
        status_nxt         = batb_pkg::ST_GROUPED;
      end else if (held_count_r >= ring_n && !overwrite_enable_r) begin
        status_nxt = batb_pkg::ST_DROPPED;
      end else begin
        mem_we             = 1'b1;
        newest_key_nxt     = in_key;
        newest_base_nxt    = in_window_base;
        newest_offset_nxt  = in_access_offset;
        newest_repeats_nxt = {31'd0, in_group_mode};
        newest_addr_nxt    = write_pointer_r;
        write_pointer_nxt  = (wp_inc == ring_n) ? '0 : wp_inc[AW-1:0];
        if (held_count_r < ring_n) begin
          held_count_nxt = held_count_r + CW'(1);
        end
        status_nxt = batb_pkg::ST_NEW;
      end
    end

    if (cfg_we && batb_pkg::cfg_idx_t'(cfg_index) == batb_pkg::CFG_ENTRIES_IN_USE) begin
      write_pointer_nxt = '0;
      held_count_nxt    = '0;
    end
  end

  // The in-place repeat update rewrites the whole entry word. Only the
  // repeat count may change, so the other fields are taken from the copy
  // of the newest entry held in a shadow word.
  batb_pkg::entry_t newest_word_r;
  batb_pkg::entry_t mem_wword;

  always_comb begin
    mem_wword = mem_wdata;
    if (mem_we && status_nxt == batb_pkg::ST_GROUPED) begin
      mem_wword         = newest_word_r;
      mem_wword.repeats = newest_repeats_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wword;
      newest_word_r  <= mem_wword;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_in_use_r   <= 11'(batb_pkg::LOG_DEPTH);
      overwrite_enable_r <= 1'b1;
      window_count_r     <= '0;
      last_window_open_r <= 1'b0;
      window0_start_r    <= '0;
      window0_end_r      <= '0;
      window1_start_r    <= '0;
      window1_end_r      <= '0;
    end else if (cfg_we) begin
      unique case (batb_pkg::cfg_idx_t'(cfg_index))
        batb_pkg::CFG_ENTRIES_IN_USE:   entries_in_use_r   <= cfg_wdata[10:0];
        batb_pkg::CFG_OVERWRITE_ENABLE: overwrite_enable_r <= cfg_wdata[0];
        batb_pkg::CFG_WINDOW_COUNT:     window_count_r     <= cfg_wdata[1:0];
        batb_pkg::CFG_LAST_WINDOW_OPEN: last_window_open_r <= cfg_wdata[0];
        batb_pkg::CFG_WINDOW0_START:    window0_start_r    <= cfg_wdata;
        batb_pkg::CFG_WINDOW0_END:      window0_end_r      <= cfg_wdata;
        batb_pkg::CFG_WINDOW1_START:    window1_start_r    <= cfg_wdata;
        batb_pkg::CFG_WINDOW1_END:      window1_end_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Ring control and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_pointer_r <= '0;
      held_count_r    <= '0;
      out_valid_r     <= 1'b0;
      read_ok_r       <= 1'b0;
    end else begin
      write_pointer_r <= write_pointer_nxt;
      held_count_r    <= held_count_nxt;
      out_valid_r     <= accept;
      read_ok_r       <= accept && in_action && read_hit;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    newest_key_r     <= newest_key_nxt;
    newest_base_r    <= newest_base_nxt;
    newest_offset_r  <= newest_offset_nxt;
    newest_repeats_r <= newest_repeats_nxt;
    newest_addr_r    <= newest_addr_nxt;
    status_r         <= status_nxt;
    stored_count_r   <= held_count_nxt;
  end

  // Entry fields are zero on everything but a successful read.
  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_stored_count  = stored_count_r;
  assign out_entry_time    = read_ok_r ? rdata_r.time_stamp : '0;
  assign out_entry_data    = read_ok_r ? rdata_r.data       : '0;
  assign out_entry_base    = read_ok_r ? rdata_r.base       : '0;
  assign out_entry_offset  = read_ok_r ? rdata_r.offset     : '0;
  assign out_entry_repeats = read_ok_r ? rdata_r.repeats    : '0;
  assign out_entry_bar     = read_ok_r ? rdata_r.key.bar    : '0;
  assign out_entry_write   = read_ok_r ? rdata_r.key.write  : 1'b0;
  assign out_entry_space   = read_ok_r ? rdata_r.key.space  : '0;
  assign out_entry_len     = read_ok_r ? rdata_r.key.len    : '0;

endmodule

/* hw/rtl/batb_checker.sv */
module batb_assertions (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_action,
  input logic        out_valid,
  input logic [2:0]  out_status,
  input logic [10:0] out_stored_count,
  input logic [31:0] out_entry_repeats,
  input logic [63:0] out_entry_time
);

  // Every command transfer gives exactly one result, in the cycle after it.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (out_valid == $past(start && !busy)))
    else $error("result strobe does not follow the command transfer");

  // A read command yields a read status, a log command a log status.
  a_status_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_status[2] == $past(in_action)))
    else $error("status kind does not match the command");

  // The store never reports more entries than its depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_stored_count <= 11'(batb_pkg::LOG_DEPTH)))
    else $error("stored count beyond store depth");

  // Results other than a good read carry zero entry fields.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != batb_pkg::ST_READ_OK) |->
      (out_entry_repeats == '0 && out_entry_time == '0))
    else $error("entry fields not zero outside a good read");

endmodule

bind bus_access_trace_buffer_unit batb_assertions u_batb_assertions (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_action        (in_action),
  .out_valid        (out_valid),
  .out_status       (out_status),
  .out_stored_count (out_stored_count),
  .out_entry_repeats(out_entry_repeats),
  .out_entry_time   (out_entry_time)
);

/* tb/batb_checker.sv */
module batb_checker
  import batb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_wdata,
  input  logic              start,
  input  logic              busy,
  input  logic              in_action,
  input  logic              in_group_mode,
  input  logic [63:0]       in_now_time,
  input  logic [2:0]        in_bar_number,
  input  logic              in_is_write,
  input  logic [1:0]        in_space_type,
  input  logic [63:0]       in_window_base,
  input  logic [31:0]       in_access_offset,
  input  logic [7:0]        in_access_len,
  input  logic [63:0]       in_access_data,
  input  logic [9:0]        in_read_index,
  input  logic              out_valid,
  input  logic [2:0]        out_status,
  input  logic [10:0]       out_stored_count,
  input  logic [63:0]       out_entry_time,
  input  logic [63:0]       out_entry_data,
  input  logic [63:0]       out_entry_base,
  input  logic [31:0]       out_entry_offset,
  input  logic [31:0]       out_entry_repeats,
  input  logic [2:0]        out_entry_bar,
  input  logic              out_entry_write,
  input  logic [1:0]        out_entry_space,
  input  logic [7:0]        out_entry_len,
  output int unsigned       fail_count,
  output int unsigned       pending
);

  typedef struct packed {
    status_t     status;
    logic [10:0] count;
    entry_t      entry;
  } trace_result_t;

  // Shadow copy of the trace store, its pointers and the register file.
  entry_t        trace_mem [LOG_DEPTH];
  logic [10:0]   head_ptr;
  logic [10:0]   fill;
  logic [10:0]   ring_reg;
  logic          ovw_en;
  logic [1:0]    win_cnt;
  logic          open_last;
  logic [63:0]   win0_lo, win0_hi, win1_lo, win1_hi;

  trace_result_t due_results [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic int unsigned ring_len();
    if (ring_reg == 0) return 1;
    if (ring_reg > LOG_DEPTH) return LOG_DEPTH;
    return 32'(ring_reg);
  endfunction

  function automatic bit in_span(logic [63:0] t, logic [63:0] lo, logic [63:0] hi, bit open);
    if (t < lo) return 0;
    return open || (t < hi);
  endfunction

  // A window count of three behaves like two.
  function automatic bit time_kept(logic [63:0] t);
    if (win_cnt == 0) return 1;
    if (win_cnt == 1) return in_span(t, win0_lo, win0_hi, open_last);
    return in_span(t, win0_lo, win0_hi, 0) || in_span(t, win1_lo, win1_hi, open_last);
  endfunction

  // Applies one command to the shadow store and returns the result it must produce.
  function automatic trace_result_t predict_trace_step(
    logic act, logic grp, logic [63:0] now, logic [2:0] bar, logic wr,
    logic [1:0] space, logic [63:0] base, logic [31:0] offs, logic [7:0] len,
    logic [63:0] data, logic [9:0] rd_idx);
    trace_result_t r;
    int unsigned   n;
    int unsigned   slot;
    key_t          key;
    bit            merged;
    r        = '0;
    r.status = ST_NEW;
    n        = ring_len();
    if (act) begin
      if (rd_idx < fill) begin
        slot     = (head_ptr + n - fill + rd_idx) % n;
        r.status = ST_READ_OK;
        r.entry  = trace_mem[slot];
      end else begin
        r.status = ST_READ_RANGE;
      end
    end else begin
      key.bar   = bar;
      key.write = wr;
      key.space = space;
      key.len   = len;
      if (!time_kept(now)) begin
        r.status = ST_OUTSIDE;
      end else begin
        merged = 0;
        // A grouped repeat bumps the newest entry, even in a full store that drops.
        if (grp && fill > 0) begin
          slot = (head_ptr + n - 1) % n;
          if (trace_mem[slot].key == key && trace_mem[slot].base == base &&
              trace_mem[slot].offset == offs) begin
            trace_mem[slot].repeats = trace_mem[slot].repeats + 32'd1;
            r.status = ST_GROUPED;
            merged   = 1;
          end
        end
        if (!merged) begin
          if (fill >= n && !ovw_en) begin
            r.status = ST_DROPPED;
          end else begin
            slot = head_ptr % n;
            if (len < 8) data = data & ((64'd1 << (8 * len)) - 64'd1);
            trace_mem[slot].time_stamp = now;
            trace_mem[slot].data       = data;
            trace_mem[slot].base       = base;
            trace_mem[slot].offset     = offs;
            trace_mem[slot].repeats    = grp ? 32'd1 : 32'd0;
            trace_mem[slot].key        = key;
            head_ptr = 11'((slot + 1) % n);
            if (fill < n) fill = fill + 11'd1;
          end
        end
      end
    end
    r.count = fill;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 100) $display("%0t: mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string what, input logic [63:0] got, input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %h, expected %h", what, got, want));
  endtask

  always @(posedge clk) begin
    trace_result_t want;
    if (!rst_n) begin
      head_ptr  = '0;
      fill      = '0;
      ring_reg  = 11'(LOG_DEPTH);
      ovw_en    = 1'b1;
      win_cnt   = '0;
      open_last = 1'b0;
      win0_lo   = '0;
      win0_hi   = '0;
      win1_lo   = '0;
      win1_hi   = '0;
      due_results.delete();
    end else begin
      // The result shown now belongs to the oldest command still waiting.
      if (out_valid === 1'b1) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result with status %0d and no command waiting",
                                    out_status));
        end else begin
          want = due_results.pop_front();
          check_field("status", 64'(out_status), 64'(want.status));
          check_field("stored_count", 64'(out_stored_count), 64'(want.count));
          check_field("entry_time", out_entry_time, want.entry.time_stamp);
          check_field("entry_data", out_entry_data, want.entry.data);
          check_field("entry_base", out_entry_base, want.entry.base);
          check_field("entry_offset", 64'(out_entry_offset), 64'(want.entry.offset));
          check_field("entry_repeats", 64'(out_entry_repeats), 64'(want.entry.repeats));
          check_field("entry_bar", 64'(out_entry_bar), 64'(want.entry.key.bar));
          check_field("entry_write", 64'(out_entry_write), 64'(want.entry.key.write));
          check_field("entry_space", 64'(out_entry_space), 64'(want.entry.key.space));
          check_field("entry_len", 64'(out_entry_len), 64'(want.entry.key.len));
        end
      end else if (out_valid !== 1'b0) begin
        report_mismatch("out_valid is unknown");
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENTRIES_IN_USE: begin
            ring_reg = cfg_wdata[10:0];
            head_ptr = '0;
            fill     = '0;
          end
          CFG_OVERWRITE_ENABLE: ovw_en    = cfg_wdata[0];
          CFG_WINDOW_COUNT:     win_cnt   = cfg_wdata[1:0];
          CFG_LAST_WINDOW_OPEN: open_last = cfg_wdata[0];
          CFG_WINDOW0_START:    win0_lo   = cfg_wdata;
          CFG_WINDOW0_END:      win0_hi   = cfg_wdata;
          CFG_WINDOW1_START:    win1_lo   = cfg_wdata;
          CFG_WINDOW1_END:      win1_hi   = cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy)
        due_results.push_back(predict_trace_step(in_action, in_group_mode, in_now_time,
          in_bar_number, in_is_write, in_space_type, in_window_base, in_access_offset,
          in_access_len, in_access_data, in_read_index));
    end
    pending = due_results.size();
  end

endmodule

/* tb/tb.sv */
module tb;
  import batb_pkg::*;

  // One command as the sender sees it, before it is put on the in_ ports.
  typedef struct packed {
    logic        act;
    logic        grp;
    logic [63:0] now;
    logic [2:0]  bar;
    logic        wr;
    logic [1:0]  space;
    logic [63:0] base;
    logic [31:0] offs;
    logic [7:0]  len;
    logic [63:0] data;
    logic [9:0]  rd_idx;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_wdata;
  logic        start;
  logic        busy;
  logic        in_action;
  logic        in_group_mode;
  logic [63:0] in_now_time;
  logic [2:0]  in_bar_number;
  logic        in_is_write;
  logic [1:0]  in_space_type;
  logic [63:0] in_window_base;
  logic [31:0] in_access_offset;
  logic [7:0]  in_access_len;
  logic [63:0] in_access_data;
  logic [9:0]  in_read_index;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [10:0] out_stored_count;
  logic [63:0] out_entry_time;
  logic [63:0] out_entry_data;
  logic [63:0] out_entry_base;
  logic [31:0] out_entry_offset;
  logic [31:0] out_entry_repeats;
  logic [2:0]  out_entry_bar;
  logic        out_entry_write;
  logic [1:0]  out_entry_space;
  logic [7:0]  out_entry_len;
  int unsigned fail_count;
  int unsigned pending;

  // Sender-side view of the register file. It only shapes the stimulus, so that
  // timestamps land on window edges and read indexes land near the ring size.
  int unsigned tb_ring = LOG_DEPTH;
  int unsigned tb_wc   = 0;
  logic [63:0] tb_win [4];

  // The last access that was logged. Half of the random log events repeat it,
  // which is the only way to get past the first entry into the grouping logic.
  cmd_t last_log = '0;

  int unsigned n_logs   = 0;
  int unsigned n_reads  = 0;
  int unsigned n_writes = 0;

  always #4 clk = ~clk;

  bus_access_trace_buffer_unit u_dut (.*);

  // The checker watches both channels and the register port, and predicts.
  batb_checker u_chk (.*);

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_addr();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return 64'($urandom_range(0, 15)) << 12;
      default: return rand64();
    endcase
  endfunction

  // Timestamps cluster on both sides of every window edge, with some spread
  // inside the windows and some fully random values.
  function automatic logic [63:0] pick_time();
    case ($urandom_range(0, 11))
      0:       return tb_win[0] - 64'd1;
      1:       return tb_win[0];
      2:       return tb_win[1] - 64'd1;
      3:       return tb_win[1];
      4:       return tb_win[2] - 64'd1;
      5:       return tb_win[2];
      6:       return tb_win[3] - 64'd1;
      7:       return tb_win[3];
      8:       return tb_win[0] + 64'($urandom_range(0, 1200));
      9:       return tb_win[2] + 64'($urandom_range(0, 1200));
      10:      return 64'($urandom_range(0, 3000));
      default: return rand64();
    endcase
  endfunction

  function automatic cmd_t mk_log(logic grp, logic [63:0] now, logic [2:0] bar, logic wr,
                                  logic [1:0] space, logic [63:0] base, logic [31:0] offs,
                                  logic [7:0] len, logic [63:0] data);
    cmd_t c;
    c.act    = 1'b0;
    c.grp    = grp;
    c.now    = now;
    c.bar    = bar;
    c.wr     = wr;
    c.space  = space;
    c.base   = base;
    c.offs   = offs;
    c.len    = len;
    c.data   = data;
    c.rd_idx = 10'($urandom);
    last_log = c;
    return c;
  endfunction

  // Read-out request. The access fields carry noise, since the block ignores them.
  function automatic cmd_t mk_read(logic [9:0] idx);
    cmd_t c;
    c        = CMD_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom});
    c.act    = 1'b1;
    c.rd_idx = idx;
    return c;
  endfunction

  function automatic cmd_t rand_read();
    int unsigned top_idx;
    top_idx = (tb_ring > 1023) ? 1023 : tb_ring;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return mk_read(10'($urandom_range(0, top_idx)));
      6:                return mk_read('0);
      7:                return mk_read(10'(top_idx - 1));
      default:          return mk_read(10'($urandom));
    endcase
  endfunction

  // Half of the log events repeat the last access exactly, some differ from it
  // in a single field, and the rest are fresh accesses.
  function automatic cmd_t rand_log();
    cmd_t        c;
    int unsigned pick;
    c    = last_log;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      c.grp = ($urandom_range(0, 9) != 0);
    end else if (pick < 62) begin
      c.grp = 1'b1;
      case ($urandom_range(0, 5))
        0:       c.bar   = 3'((c.bar + 1) % 7);
        1:       c.wr    = ~c.wr;
        2:       c.space = 2'((c.space + 1) % 3);
        3:       c.base  = c.base ^ (64'd1 << $urandom_range(0, 63));
        4:       c.offs  = c.offs ^ (32'd1 << $urandom_range(0, 31));
        default: c.len   = c.len + 8'd1;
      endcase
    end else begin
      c.grp   = 1'($urandom);
      c.bar   = 3'($urandom_range(0, 6));
      c.wr    = 1'($urandom);
      c.space = 2'($urandom_range(0, 2));
      c.base  = pick_addr();
      c.offs  = ($urandom_range(0, 2) == 0) ? $urandom : 32'($urandom_range(0, 255) * 4);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: c.len = 8'($urandom_range(0, 8));
        5:             c.len = 8'hFF;
        default:       c.len = 8'($urandom);
      endcase
    end
    return mk_log(c.grp, pick_time(), c.bar, c.wr, c.space, c.base, c.offs, c.len,
                  rand64());
  endfunction

  // Drives one command from a falling edge and returns at the rising edge that
  // completes the transfer. Inputs only ever change at falling edges. Each cycle
  // before the transfer is left idle with the given chance in percent.
  task automatic issue(input cmd_t c, input int unsigned idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start            = 1'b1;
    in_action        = c.act;
    in_group_mode    = c.grp;
    in_now_time      = c.now;
    in_bar_number    = c.bar;
    in_is_write      = c.wr;
    in_space_type    = c.space;
    in_window_base   = c.base;
    in_access_offset = c.offs;
    in_access_len    = c.len;
    in_access_data   = c.data;
    in_read_index    = c.rd_idx;
    while (busy !== 1'b0) @(negedge clk);
    @(posedge clk);
    if (c.act) n_reads++;
    else n_logs++;
  endtask

  task automatic run_random(input int unsigned items, input int unsigned idle_pct);
    repeat (items) begin
      if ($urandom_range(0, 99) < 25) issue(rand_read(), idle_pct);
      else issue(rand_log(), idle_pct);
    end
  endtask

  // Holds the sender off until every result owed by the block has come back.
  // Each command yields its result in the cycle after the transfer, so the block
  // is left fully idle.
  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic set_reg(input cfg_idx_t idx, input logic [63:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    n_writes++;
    case (idx)
      CFG_ENTRIES_IN_USE:
        tb_ring = (value[10:0] == 0) ? 1 :
                  (value[10:0] > LOG_DEPTH) ? LOG_DEPTH : 32'(value[10:0]);
      CFG_WINDOW_COUNT:  tb_wc     = 32'(value[1:0]);
      CFG_WINDOW0_START: tb_win[0] = value;
      CFG_WINDOW0_END:   tb_win[1] = value;
      CFG_WINDOW1_START: tb_win[2] = value;
      CFG_WINDOW1_END:   tb_win[3] = value;
      default: ;
    endcase
  endtask

  // Rewrites the whole register file once the block has gone idle. Writing the
  // ring size also empties the store, so each phase starts from an empty trace.
  task automatic phase(input int unsigned ring, input bit ovw, input int unsigned wc,
                       input bit open, input logic [63:0] s0, input logic [63:0] e0,
                       input logic [63:0] s1, input logic [63:0] e1);
    wait_idle();
    set_reg(CFG_ENTRIES_IN_USE, 64'(ring));
    set_reg(CFG_OVERWRITE_ENABLE, 64'(ovw));
    set_reg(CFG_WINDOW_COUNT, 64'(wc));
    set_reg(CFG_LAST_WINDOW_OPEN, 64'(open));
    set_reg(CFG_WINDOW0_START, s0);
    set_reg(CFG_WINDOW0_END, e0);
    set_reg(CFG_WINDOW1_START, s1);
    set_reg(CFG_WINDOW1_END, e1);
  endtask

  // A fixed ceiling far above the slowest correct run; a hung handshake or a
  // lost result ends here.
  initial begin
    #3200000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    tb_win           = '{default: '0};
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;
    start            = 1'b0;
    in_action        = 1'b0;
    in_group_mode    = 1'b0;
    in_now_time      = '0;
    in_bar_number    = '0;
    in_is_write      = 1'b0;
    in_space_type    = '0;
    in_window_base   = '0;
    in_access_offset = '0;
    in_access_len    = '0;
    in_access_data   = '0;
    in_read_index    = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part, first with the register values that reset leaves behind.
    // Reads of an empty store are out of range at both ends of the index field.
    issue(mk_read('0), 0);
    issue(mk_read(10'h3FF), 0);
    // An access with every field at its top value.
    issue(mk_log(1'b0, '1, 3'd6, 1'b1, 2'd2, '1, '1, 8'hFF, '1), 0);
    // A zero-length grouped access captures no data and starts its count at one;
    // the two repeats only bump that count.
    repeat (3) issue(mk_log(1'b1, '0, 3'd0, 1'b0, 2'd0, '0, '0, 8'd0, '1), 0);
    // A different offset opens a new entry. The same access ungrouped opens
    // another one with a zero count, and a grouped repeat then bumps it.
    issue(mk_log(1'b1, 64'd5, 3'd0, 1'b0, 2'd0, '0, 32'd4, 8'd0, '1), 0);
    issue(mk_log(1'b0, 64'd6, 3'd0, 1'b0, 2'd0, '0, 32'd4, 8'd0, '1), 0);
    issue(mk_log(1'b1, 64'd7, 3'd0, 1'b0, 2'd0, '0, 32'd4, 8'd0, '1), 0);
    // Data masking just below, at and above eight bytes.
    for (int i = 0; i < 4; i++)
      issue(mk_log(1'b0, 64'(10 + i), 3'd1, 1'b1, 2'd1, 64'h1000, 32'h10, 8'(6 + i),
                   rand64()), 0);
    // Eight entries are held now: the oldest, the newest and the first past the end.
    issue(mk_read(10'd0), 0);
    issue(mk_read(10'd7), 0);
    issue(mk_read(10'd8), 0);

    // A single-entry ring that drops when full. The second access is dropped,
    // but a grouped repeat of the held entry still counts.
    phase(1, 1'b0, 0, 1'b0, '0, '0, '0, '0);
    issue(mk_log(1'b1, 64'd20, 3'd5, 1'b0, 2'd1, 64'hABC0, 32'h8, 8'd4, rand64()), 0);
    issue(mk_log(1'b0, 64'd21, 3'd2, 1'b1, 2'd2, 64'hABC0, 32'h8, 8'd4, rand64()), 0);
    issue(mk_log(1'b1, 64'd22, 3'd5, 1'b0, 2'd1, 64'hABC0, 32'h8, 8'd4, rand64()), 0);
    issue(mk_read(10'd0), 0);
    issue(mk_read(10'd1), 0);

    // Full-size ring with overwrite and no windows. The first stretch runs back
    // to back; midway the sender stops until every result is back.
    phase(LOG_DEPTH, 1'b1, 0, 1'b0, '0, '0, '0, '0);
    run_random(150, 0);
    run_random(100, 14);
    wait_idle();
    run_random(100, 14);

    phase(1, 1'b0, 0, 1'b0, '0, '0, '0, '0);
    run_random(80, 14);
    // One closed window on a small overwriting ring, then a later-starting window
    // left open on a dropping ring.
    phase(5, 1'b1, 1, 1'b0, 64'd1000, 64'd2000, '0, '0);
    run_random(120, 14);
    phase(5, 1'b0, 1, 1'b1, 64'd1500, '0, '0, '0);
    run_random(100, 14);
    // Two closed windows with a gap between them.
    phase(16, 1'b1, 2, 1'b0, 64'd100, 64'd200, 64'd300, 64'd400);
    run_random(150, 14);
    // An empty first window, so only the open second one passes events.
    phase(9, 1'b0, 2, 1'b1, 64'd500, 64'd500, 64'h8000_0000_0000_0000, '0);
    run_random(120, 14);
    // A window count of three with a full-range first window and an empty second.
    phase(3, 1'b1, 3, 1'b0, '0, '1, '1, '0);
    run_random(120, 14);
    // A ring size of zero acts as one entry.
    phase(0, 1'b1, 0, 1'b0, '0, '0, '0, '0);
    run_random(80, 14);
    // A ring size above the store depth acts as the full depth; only the very
    // last timestamp passes the open window.
    phase(2047, 1'b0, 1, 1'b1, '1, '0, '0, '0);
    run_random(100, 14);
    // A one-tick first window and an open second window at the top of time.
    phase(37, 1'b1, 2, 1'b1, '0, 64'd1, '1, '0);
    run_random(150, 14);

    wait_idle();
    repeat (4) @(posedge clk);
    $display("Run covered %0d log events and %0d read-outs across %0d register writes.",
             n_logs, n_reads, n_writes);
    $display("Ring sizes from zero to past the depth, drop and overwrite, zero to three windows.");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
